// File: hdl/mdc_pkg.sv
// Shared types and constants for the mecanum drive distance controller.
`default_nettype none

package mdc_pkg;

   localparam int CountWidth  = 32;
   localparam int TargetWidth = 31;
   localparam int SpeedWidth  = 9;
   localparam int DutyWidth   = 8;
   localparam int ImbWidth    = 35;
   localparam int ClipWidth   = 13;
   localparam int CorrWidth   = 10;
   localparam int DriveWidth  = 12;
   localparam int AddrWidth   = 3;

   // floor(x * Recip10 / 2^16) == floor(x / 10) for x below 2^ClipWidth
   localparam logic [ClipWidth-1:0] Recip10 = 13'd6554;
   localparam logic [DutyWidth-1:0] DutyMax = 8'd255;

   typedef enum logic {
      OP_START  = 1'b0,
      OP_SAMPLE = 1'b1
   } op_type;

   typedef enum logic {
      REG_TARGET_COUNTS = 1'b0,
      REG_DRIVE_SPEED   = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic                         op;
      logic signed [CountWidth-1:0] front_left_count;
      logic signed [CountWidth-1:0] front_right_count;
      logic signed [CountWidth-1:0] back_left_count;
      logic signed [CountWidth-1:0] back_right_count;
   } req_type;

   typedef struct packed {
      logic [DutyWidth-1:0] fl_magnitude;
      logic                 fl_forward;
      logic [DutyWidth-1:0] fr_magnitude;
      logic                 fr_forward;
      logic [DutyWidth-1:0] bl_magnitude;
      logic                 bl_forward;
      logic [DutyWidth-1:0] br_magnitude;
      logic                 br_forward;
      logic                 done_res;
   } rsp_type;

   // Intermediate values between the two compute stages
   typedef struct packed {
      logic                  op;
      logic [CountWidth-1:0] mean;
      logic                  imb_neg;
      logic                  imb_sat;
      logic [ClipWidth-1:0]  imb_mag;
   } prep_type;

endpackage

`default_nettype wire

// File: hdl/mdc_prep.sv
// First compute stage: mean absolute count and clipped left/right imbalance.
`default_nettype none

module mdc_prep (
   input  mdc_pkg::req_type  req,
   output mdc_pkg::prep_type prep
);

   logic [mdc_pkg::CountWidth-1:0]   abs_fl;
   logic [mdc_pkg::CountWidth-1:0]   abs_fr;
   logic [mdc_pkg::CountWidth-1:0]   abs_bl;
   logic [mdc_pkg::CountWidth-1:0]   abs_br;
   logic [mdc_pkg::CountWidth+1:0]   abs_sum;
   logic [mdc_pkg::ImbWidth-1:0]     imb;
   logic [mdc_pkg::ImbWidth-1:0]     imb_abs;

   function automatic logic [mdc_pkg::CountWidth-1:0] abs32(
      input logic [mdc_pkg::CountWidth-1:0] x
   );
      abs32 = x[mdc_pkg::CountWidth-1] ? (~x + 32'd1) : x;
   endfunction

   function automatic logic [mdc_pkg::ImbWidth-1:0] sx(
      input logic [mdc_pkg::CountWidth-1:0] x
   );
      sx = {{(mdc_pkg::ImbWidth-mdc_pkg::CountWidth){x[mdc_pkg::CountWidth-1]}}, x};
   endfunction

   always_comb begin
      abs_fl  = abs32(req.front_left_count);
      abs_fr  = abs32(req.front_right_count);
      abs_bl  = abs32(req.back_left_count);
      abs_br  = abs32(req.back_right_count);
      abs_sum = {2'b00, abs_fl} + {2'b00, abs_fr} + {2'b00, abs_bl} + {2'b00, abs_br};

      imb = sx(req.front_left_count) - sx(req.front_right_count)
          + sx(req.back_left_count) - sx(req.back_right_count);
      imb_abs = imb[mdc_pkg::ImbWidth-1] ? (~imb + 35'd1) : imb;

      prep.op      = req.op;
      prep.mean    = abs_sum[mdc_pkg::CountWidth+1:2];
      prep.imb_neg = imb[mdc_pkg::ImbWidth-1];
      // beyond the clip range the correction saturates every wheel anyway
      prep.imb_sat = |imb_abs[mdc_pkg::ImbWidth-1:mdc_pkg::ClipWidth];
      prep.imb_mag = imb_abs[mdc_pkg::ClipWidth-1:0];
   end

endmodule

`default_nettype wire

// File: hdl/mdc_mix.sv
// Second compute stage: target check, correction and wheel mixing.
`default_nettype none

module mdc_mix (
   input  mdc_pkg::prep_type                     prep,
   input  logic                                  finished,
   input  logic [mdc_pkg::TargetWidth-1:0]       target_counts,
   input  logic signed [mdc_pkg::SpeedWidth-1:0] drive_speed,
   output mdc_pkg::rsp_type                      rsp,
   output logic                                  finished_next
);

   logic [2*mdc_pkg::ClipWidth-1:0]  prod;
   logic [mdc_pkg::CorrWidth-1:0]    corr_mag;
   logic [mdc_pkg::DriveWidth-1:0]   corr;
   logic [mdc_pkg::DriveWidth-1:0]   speed_x;
   logic [mdc_pkg::DriveWidth-1:0]   left;
   logic [mdc_pkg::DriveWidth-1:0]   right;
   logic                             run;
   logic                             reached;

   function automatic logic [mdc_pkg::DutyWidth:0] wheel(
      input logic [mdc_pkg::DriveWidth-1:0] d
   );
      logic [mdc_pkg::DriveWidth-1:0] m;
      m = d[mdc_pkg::DriveWidth-1] ? (~d + 12'd1) : d;
      if (|m[mdc_pkg::DriveWidth-1:mdc_pkg::DutyWidth]) begin
         wheel = {mdc_pkg::DutyMax, ~d[mdc_pkg::DriveWidth-1]};
      end else begin
         wheel = {m[mdc_pkg::DutyWidth-1:0], ~d[mdc_pkg::DriveWidth-1]};
      end
   endfunction

   always_comb begin
      prod     = prep.imb_mag * mdc_pkg::Recip10;
      corr_mag = prep.imb_sat ? {mdc_pkg::CorrWidth{1'b1}}
                              : prod[2*mdc_pkg::ClipWidth-1:16];
      corr     = prep.imb_neg ? (~{2'b00, corr_mag} + 12'd1) : {2'b00, corr_mag};
      speed_x  = {{(mdc_pkg::DriveWidth-mdc_pkg::SpeedWidth){drive_speed[mdc_pkg::SpeedWidth-1]}},
                  drive_speed};

      reached       = prep.mean >= {1'b0, target_counts};
      run           = 1'b0;
      finished_next = finished;
      rsp.done_res  = 1'b0;
      unique case (prep.op)
         mdc_pkg::OP_START: begin
            finished_next = 1'b0;
         end
         mdc_pkg::OP_SAMPLE: begin
            if (finished) begin
               rsp.done_res = 1'b1;
            end else if (reached) begin
               finished_next = 1'b1;
               rsp.done_res  = 1'b1;
            end else begin
               run = 1'b1;
            end
         end
         default: begin
            finished_next = finished;
         end
      endcase

      left  = run ? (speed_x - corr) : '0;
      right = run ? (speed_x + corr) : '0;
      {rsp.fl_magnitude, rsp.fl_forward} = wheel(left);
      {rsp.fr_magnitude, rsp.fr_forward} = wheel(right);
      {rsp.bl_magnitude, rsp.bl_forward} = wheel(left);
      {rsp.br_magnitude, rsp.br_forward} = wheel(right);
   end

endmodule

`default_nettype wire

// File: hdl/mecanum_drive_distance_controller.sv
// Top level of the mecanum drive distance controller.
// Usage:
//   Write target_counts (address 0) and drive_speed (address 4) over the csr
//   port while the block is idle. Send a start item (op 0) to begin a move,
//   then one sample item (op 1) per encoder reading. Each item gives exactly
//   one result: four wheel duties with direction bits and a done flag.
//   Once the mean absolute count reaches the target, done stays set and all
//   wheels are stopped until the next start item.
// Timing:
//   Three register stages (input, intermediate, result), passed in that
//   order. One item per cycle is sustained while rsp_stall is low; the
//   finished flag updates as each item enters the result stage.
// Reset:
//   Synchronous, active high; clears the pipeline, the finished flag and both
//   registers.
// Backpressure:
//   While rsp_stall holds a result, stages behind it keep filling; req_stall
//   rises only when every stage is full.
`default_nettype none

module mecanum_drive_distance_controller (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  mdc_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output mdc_pkg::rsp_type                rsp_data,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [mdc_pkg::AddrWidth-1:0]   csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);

   logic                                  in_valid_ff;
   mdc_pkg::req_type                      in_data_ff;
   logic                                  mid_valid_ff;
   mdc_pkg::prep_type                     mid_ff;
   logic                                  rsp_valid_ff;
   mdc_pkg::rsp_type                      rsp_ff;
   logic                                  finished_ff;
   logic [mdc_pkg::TargetWidth-1:0]       target_ff;
   logic signed [mdc_pkg::SpeedWidth-1:0] speed_ff;

   mdc_pkg::prep_type                     mid_in;
   mdc_pkg::rsp_type                      rsp_in;
   logic                                  finished_in;
   logic                                  out_en;
   logic                                  mid_en;
   logic                                  in_en;
   logic                                  csr_wr;
   mdc_pkg::reg_index_type                csr_idx;

   mdc_prep u_prep (
      .req  (in_data_ff),
      .prep (mid_in)
   );

   mdc_mix u_mix (
      .prep          (mid_ff),
      .finished      (finished_ff),
      .target_counts (target_ff),
      .drive_speed   (speed_ff),
      .rsp           (rsp_in),
      .finished_next (finished_in)
   );

   assign out_en    = !rsp_valid_ff || !rsp_stall;
   assign mid_en    = !mid_valid_ff || out_en;
   assign in_en     = !in_valid_ff || mid_en;
   assign req_stall = !in_en;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         mid_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         finished_ff  <= 1'b0;
      end else begin
         if (in_en) begin
            in_valid_ff <= req_valid;
         end
         if (mid_en) begin
            mid_valid_ff <= in_valid_ff;
         end
         if (out_en) begin
            rsp_valid_ff <= mid_valid_ff;
            if (mid_valid_ff) begin
               finished_ff <= finished_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_en) begin
         in_data_ff <= req_data;
      end
      if (mid_en) begin
         mid_ff <= mid_in;
      end
      if (out_en) begin
         rsp_ff <= rsp_in;
      end
   end

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = mdc_pkg::reg_index_type'(csr_paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
         speed_ff  <= '0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            mdc_pkg::REG_TARGET_COUNTS: target_ff <= csr_pwdata[mdc_pkg::TargetWidth-1:0];
            mdc_pkg::REG_DRIVE_SPEED:   speed_ff  <= csr_pwdata[mdc_pkg::SpeedWidth-1:0];
            default:                    target_ff <= target_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         mdc_pkg::REG_TARGET_COUNTS: csr_prdata = {1'b0, target_ff};
         mdc_pkg::REG_DRIVE_SPEED:
            csr_prdata = {{(32-mdc_pkg::SpeedWidth){speed_ff[mdc_pkg::SpeedWidth-1]}}, speed_ff};
         default:                    csr_prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

// File: sim/mdc_checker.sv
// Checker for the mecanum drive controller: predicts wheel commands and compares results.
module mdc_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  mdc_pkg::req_type              req_data,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  mdc_pkg::rsp_type              rsp_data,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic                          csr_pready,
   input  logic [mdc_pkg::AddrWidth-1:0] csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output int                            mismatches,
   output int                            pending
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [mdc_pkg::TargetWidth-1:0]       target_cnt;
   logic signed [mdc_pkg::SpeedWidth-1:0] speed;
   logic                                  finished;
   mdc_pkg::rsp_type                      wheel_cmd_q[$];
   mdc_pkg::rsp_type                      want;

   function automatic logic [mdc_pkg::DutyWidth-1:0] duty(input longint drive);
      longint m;
      m = (drive < 0) ? -drive : drive;
      return (m > 255) ? mdc_pkg::DutyMax : m[mdc_pkg::DutyWidth-1:0];
   endfunction

   function automatic mdc_pkg::rsp_type wheel_cmd(input longint left, input longint right,
                                                  input logic done);
      mdc_pkg::rsp_type c;
      c.fl_magnitude = duty(left);
      c.fl_forward   = (left >= 0);
      c.fr_magnitude = duty(right);
      c.fr_forward   = (right >= 0);
      c.bl_magnitude = duty(left);
      c.bl_forward   = (left >= 0);
      c.br_magnitude = duty(right);
      c.br_forward   = (right >= 0);
      c.done_res     = done;
      return c;
   endfunction

   function automatic longint abs_count(input logic signed [mdc_pkg::CountWidth-1:0] v);
      longint x;
      x = longint'($signed(v));
      return (x < 0) ? -x : x;
   endfunction

   function automatic mdc_pkg::rsp_type predict_wheel_cmd(input mdc_pkg::req_type r);
      longint mean;
      longint imb;
      longint corr;
      longint base;
      if (r.op == mdc_pkg::OP_START) begin
         finished = 1'b0;
         return wheel_cmd(0, 0, 1'b0);
      end
      if (finished)
         return wheel_cmd(0, 0, 1'b1);
      mean = (abs_count(r.front_left_count) + abs_count(r.front_right_count) +
              abs_count(r.back_left_count) + abs_count(r.back_right_count)) >> 2;
      if (mean >= longint'(target_cnt)) begin
         finished = 1'b1;
         return wheel_cmd(0, 0, 1'b1);
      end
      imb = (longint'($signed(r.front_left_count)) - longint'($signed(r.front_right_count)))
          + (longint'($signed(r.back_left_count)) - longint'($signed(r.back_right_count)));
      corr = imb / 10;
      base = longint'(speed);
      return wheel_cmd(base - corr, base + corr, 1'b0);
   endfunction

   task automatic check_field(input string name, input longint exp_val,
                              input longint act_val);
      if (exp_val != act_val) begin
         $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         wheel_cmd_q.delete();
         target_cnt = '0;
         speed      = '0;
         finished   = 1'b0;
         mismatches = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (wheel_cmd_q.size() == 0) begin
               $error("result transfer with no command pending");
               mismatches++;
            end else begin
               want = wheel_cmd_q.pop_front();
               check_field("fl_magnitude", want.fl_magnitude, rsp_data.fl_magnitude);
               check_field("fl_forward", want.fl_forward, rsp_data.fl_forward);
               check_field("fr_magnitude", want.fr_magnitude, rsp_data.fr_magnitude);
               check_field("fr_forward", want.fr_forward, rsp_data.fr_forward);
               check_field("bl_magnitude", want.bl_magnitude, rsp_data.bl_magnitude);
               check_field("bl_forward", want.bl_forward, rsp_data.bl_forward);
               check_field("br_magnitude", want.br_magnitude, rsp_data.br_magnitude);
               check_field("br_forward", want.br_forward, rsp_data.br_forward);
               check_field("done_res", want.done_res, rsp_data.done_res);
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr == {mdc_pkg::REG_TARGET_COUNTS, 2'b00})
               target_cnt = csr_pwdata[mdc_pkg::TargetWidth-1:0];
            else if (csr_paddr == {mdc_pkg::REG_DRIVE_SPEED, 2'b00})
               speed = csr_pwdata[mdc_pkg::SpeedWidth-1:0];
         end
         if (req_valid && !req_stall)
            wheel_cmd_q.push_back(predict_wheel_cmd(req_data));
      end
      pending <= wheel_cmd_q.size();
   end

endmodule

// File: sim/mecanum_drive_distance_controller_tb.sv
// Testbench top: stimulus, configuration and verdict for the mecanum drive controller.
module mecanum_drive_distance_controller_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ItemTarget = 1750;
   localparam int IdleLimit  = 4000;
   localparam logic [mdc_pkg::CountWidth-1:0]  CountMax  = 32'h7fff_ffff;
   localparam logic [mdc_pkg::CountWidth-1:0]  CountMin  = 32'h8000_0000;
   localparam logic [mdc_pkg::TargetWidth-1:0] TargetMax = 31'h7fff_ffff;

   logic                          clock;
   logic                          reset       = 1'b1;
   logic                          req_valid   = 1'b0;
   logic                          req_stall;
   mdc_pkg::req_type              req_data    = '0;
   logic                          rsp_valid;
   logic                          rsp_stall   = 1'b0;
   mdc_pkg::rsp_type              rsp_data;
   logic                          csr_psel    = 1'b0;
   logic                          csr_penable = 1'b0;
   logic                          csr_pwrite  = 1'b0;
   logic [mdc_pkg::AddrWidth-1:0] csr_paddr   = '0;
   logic [31:0]                   csr_pwdata  = '0;
   logic [31:0]                   csr_prdata;
   logic                          csr_pready;

   int   mismatches;
   int   pending;
   int   items       = 0;
   int   idle_cycles = 0;
   int   stall_left  = 0;
   bit   idle_on     = 1'b1;

   mecanum_drive_distance_controller DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   mdc_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_pready  (csr_pready),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .mismatches  (mismatches),
      .pending     (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver backpressure: mostly short stalls, occasionally long ones
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 99) < 25) begin
         stall_left = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 2)
                                                   : $urandom_range(10, 60);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IdleLimit) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (!idle_on || r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   function automatic mdc_pkg::req_type make_req(input mdc_pkg::op_type op,
                                                 input logic [31:0] fl,
                                                 input logic [31:0] fr,
                                                 input logic [31:0] bl,
                                                 input logic [31:0] br);
      mdc_pkg::req_type r;
      r.op                = op;
      r.front_left_count  = fl;
      r.front_right_count = fr;
      r.back_left_count   = bl;
      r.back_right_count  = br;
      return r;
   endfunction

   function automatic logic [31:0] sat_count(input longint v);
      if (v > 64'sd2147483647)
         return CountMax;
      if (v < -64'sd2147483648)
         return CountMin;
      return v[31:0];
   endfunction

   task automatic send(input mdc_pkg::req_type r);
      int n;
      req_data  <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items++;
      n = gap_len();
      if (n > 0) begin
         req_valid <= 1'b0;
         req_data  <= {$urandom, $urandom, $urandom, $urandom, 1'($urandom)};
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic csr_write(input mdc_pkg::reg_index_type idx, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [mdc_pkg::TargetWidth-1:0] tgt,
                            input logic signed [mdc_pkg::SpeedWidth-1:0] spd);
      drain();
      csr_write(mdc_pkg::REG_TARGET_COUNTS, {1'($urandom), tgt});
      csr_write(mdc_pkg::REG_DRIVE_SPEED, {23'($urandom), spd});
   endtask

   task automatic send_sample(input logic [31:0] fl, input logic [31:0] fr,
                              input logic [31:0] bl, input logic [31:0] br);
      send(make_req(mdc_pkg::OP_SAMPLE, fl, fr, bl, br));
   endtask

   task automatic send_start();
      send(make_req(mdc_pkg::OP_START, $urandom, $urandom, $urandom, $urandom));
   endtask

   // start followed by counts growing toward the target
   task automatic run_move(input longint tgt);
      longint step;
      longint dir;
      longint w;
      longint v[4];
      int     nsamp;
      step  = tgt / 10 + 1;
      dir   = $urandom_range(0, 1) ? 1 : -1;
      w     = (step > 8000000) ? 1000000 : step / 8 + 20;
      nsamp = $urandom_range(3, 20);
      send_start();
      for (int j = 1; j <= nsamp; j++) begin
         for (int k = 0; k < 4; k++)
            v[k] = dir * step * j + longint'($urandom_range(0, 2 * w)) - w;
         send_sample(sat_count(v[0]), sat_count(v[1]), sat_count(v[2]), sat_count(v[3]));
      end
   endtask

   initial begin
      logic [mdc_pkg::TargetWidth-1:0]       tgt;
      logic signed [mdc_pkg::SpeedWidth-1:0] spd;
      int                                    phase_end;
      int                                    r;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      configure(TargetMax, 9'sd255);
      send_start();
      send_sample(0, 0, 0, 0);
      send_sample(15, 0, 0, 0);
      send_sample(-15, 0, 0, 0);
      send_sample(9, 0, 0, 0);
      send_sample(CountMax, CountMin, 0, 0);
      send_sample(CountMin, CountMax, 0, 0);
      send_sample(-1, -1, -1, -1);
      send_sample(CountMin, CountMin, CountMin, CountMin);
      send_sample(0, 0, 0, 0);
      send_start();
      send_sample(CountMax, CountMax, CountMax, CountMax);
      send_start();
      send_sample(0, CountMax, 0, 100);
      configure(TargetMax, -9'sd255);
      send_start();
      send_sample(0, 0, 0, 0);
      send_sample(CountMin, 0, CountMin, 0);
      configure('0, 9'sd0);
      send_start();
      send_sample(0, 0, 0, 0);
      send_sample(5, -5, 7, 1);
      send_start();
      configure(31'd1000, 9'sd0);
      send_start();
      send_sample(-25, 0, 0, 0);
      send_sample(25, 0, 0, 0);

      for (int p = 1; items < ItemTarget; p++) begin
         unique case (p)
            1: begin tgt = TargetMax; spd = -9'sd255; end
            2: begin tgt = '0;        spd = 9'sd255;  end
            3: begin tgt = 31'd1;     spd = -9'sd1;   end
            default: begin
               r   = $urandom_range(0, 3);
               tgt = (r == 0) ? 31'($urandom) : (r == 1) ? 31'd0 : 31'($urandom_range(1, 5000));
               spd = 9'($urandom_range(0, 510) - 255);
            end
         endcase
         idle_on = ($urandom_range(0, 3) != 0);
         configure(tgt, spd);
         phase_end = items + 145;
         while (items < phase_end) begin
            r = $urandom_range(0, 99);
            if (r < 8)
               send_sample($urandom, $urandom, $urandom, $urandom);
            else if (r < 12)
               send_start();
            else
               run_move(longint'(tgt));
            if ($urandom_range(0, 99) < 3)
               drain();
         end
      end

      drain();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && pending == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
